// ----- hw/rtl/tgpe_pkg.sv -----
// Shared types and constants of the text glyph pixel expander.
// Used by tgpe_font_mem and text_glyph_pixel_expander; depends on nothing.
package tgpe_pkg;

  localparam int unsigned GLYPH_COLS = 8;
  localparam int unsigned GLYPH_ROWS = 8;
  localparam int unsigned COL_W      = (GLYPH_COLS > 1) ? $clog2(GLYPH_COLS) : 1;
  localparam int unsigned ROW_W      = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

  localparam int unsigned FONT_DEPTH = 2048;
  localparam int unsigned FONT_AW    = 11;
  localparam int unsigned FONT_DW    = 8;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned COLOR_W    = 32;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OP_PUT_CHAR   = 2'd0;
  localparam logic [1:0] OP_SET_CURSOR = 2'd1;
  localparam logic [1:0] OP_FONT_WRITE = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FG_COLOR     = 2'd0;
  localparam logic [1:0] REG_BG_COLOR     = 2'd1;
  localparam logic [1:0] REG_SCREEN_WIDTH = 2'd2;

  localparam logic [COLOR_W-1:0] FG_COLOR_RST     = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] BG_COLOR_RST     = 32'h0000_00FF;
  localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST = 16'd640;

  typedef struct packed {
    logic               en;
    logic [FONT_AW-1:0] addr;
    logic [FONT_DW-1:0] data;
  } font_wr_t;

  typedef struct packed {
    logic               en;
    logic [FONT_AW-1:0] addr;
  } font_rd_t;

endpackage

// ----- hw/rtl/tgpe_font_mem.sv -----
// Font store: one row byte per glyph line, one write and one registered read port.
// Clears itself after reset, one entry a cycle. Depends on tgpe_pkg.
module tgpe_font_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tgpe_pkg::font_wr_t        wr_i,
  input  tgpe_pkg::font_rd_t        rd_i,
  output logic [tgpe_pkg::FONT_DW-1:0] rdata_o,
  output logic                      ready_o
);

  logic [tgpe_pkg::FONT_DW-1:0] mem [tgpe_pkg::FONT_DEPTH];
  logic [tgpe_pkg::FONT_DW-1:0] rdata_q;
  logic [tgpe_pkg::FONT_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic                         clr_busy_q, clr_busy_d;

  logic                         we;
  logic [tgpe_pkg::FONT_AW-1:0] waddr;
  logic [tgpe_pkg::FONT_DW-1:0] wdata;

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == tgpe_pkg::FONT_AW'(tgpe_pkg::FONT_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // The clearing pass owns the write port until it has swept every entry.
  assign we    = clr_busy_q | wr_i.en;
  assign waddr = clr_busy_q ? clr_cnt_q : wr_i.addr;
  assign wdata = clr_busy_q ? '0 : wr_i.data;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = ~clr_busy_q;

endmodule

// ----- hw/rtl/text_glyph_pixel_expander.sv -----
// Top level of the text glyph pixel expander: stream ports, APB registers, sequencer.
// Depends on tgpe_pkg and tgpe_font_mem.

// After reset the font store clears itself, and no input transaction is taken
// until it is done; register writes are taken at any time. A put-character
// transaction then occupies the block for acceptance and a cursor advance (with a
// second step when the cursor wraps to the next text line) plus, for each of the
// GLYPH_ROWS glyph rows, a font read and GLYPH_COLS pixel transactions. Within a
// glyph row one pixel transaction leaves per cycle while the output side does not
// stall, limited by the single font read port and the one shared 16-bit adder that
// forms the cursor advance and every pixel coordinate. Set-cursor and font-write
// transactions, and undefined operations, each give one status transaction.
// Every output transaction stalls in the output register for as long as
// m_axis_tready is low.
module text_glyph_pixel_expander (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // char_code[7:0], new_cursor_x[23:8], new_cursor_y[39:24], font_index[50:40],
  // font_row_bits[58:51], zero fill [63:59]
  input  logic [63:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_x[15:0], pixel_y[31:16], pixel_color[63:32], cursor_x_now[79:64],
  // cursor_y_now[95:80]
  output logic [95:0] m_axis_tdata,
  // is_pixel[0]
  output logic        m_axis_tuser,
  // last
  output logic        m_axis_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = tgpe_pkg::COORD_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADV   = 3'd1;
  localparam logic [2:0] ST_ADV_Y = 3'd2;
  localparam logic [2:0] ST_ROW   = 3'd3;
  localparam logic [2:0] ST_PIX   = 3'd4;
  localparam logic [2:0] ST_STAT  = 3'd5;

  localparam logic [CW-1:0] GlyphColsW = CW'(tgpe_pkg::GLYPH_COLS);
  localparam logic [CW-1:0] GlyphRowsW = CW'(tgpe_pkg::GLYPH_ROWS);

  // Configuration registers.
  logic [tgpe_pkg::COLOR_W-1:0] fg_color_q, bg_color_q;
  logic [CW-1:0]                screen_width_q;
  logic                         cfg_wr;
  logic [1:0]                   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_color_q     <= tgpe_pkg::FG_COLOR_RST;
      bg_color_q     <= tgpe_pkg::BG_COLOR_RST;
      screen_width_q <= tgpe_pkg::SCREEN_WIDTH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tgpe_pkg::REG_FG_COLOR:     fg_color_q     <= pwdata;
        tgpe_pkg::REG_BG_COLOR:     bg_color_q     <= pwdata;
        tgpe_pkg::REG_SCREEN_WIDTH: screen_width_q <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tgpe_pkg::REG_FG_COLOR:     prdata = fg_color_q;
      tgpe_pkg::REG_BG_COLOR:     prdata = bg_color_q;
      tgpe_pkg::REG_SCREEN_WIDTH: prdata = {{(32 - CW){1'b0}}, screen_width_q};
      default:                    prdata = '0;
    endcase
  end

  // Input fields.
  logic [1:0]                   in_op;
  logic [7:0]                   in_char;
  logic [CW-1:0]                in_cur_x, in_cur_y;
  logic [tgpe_pkg::FONT_AW-1:0] in_font_idx;
  logic [tgpe_pkg::FONT_DW-1:0] in_font_bits;

  assign in_op        = s_axis_tuser;
  assign in_char      = s_axis_tdata[7:0];
  assign in_cur_x     = s_axis_tdata[23:8];
  assign in_cur_y     = s_axis_tdata[39:24];
  assign in_font_idx  = s_axis_tdata[50:40];
  assign in_font_bits = s_axis_tdata[58:51];

  // Sequencer state.
  logic [2:0]                state_q, state_d;
  logic [CW-1:0]             cursor_col_q, cursor_col_d;
  logic [CW-1:0]             cursor_row_q, cursor_row_d;
  logic [CW-1:0]             x0_q, x0_d, y0_q, y0_d, pix_y_q, pix_y_d;
  logic [7:0]                code_q, code_d;
  logic [tgpe_pkg::COL_W-1:0] col_q, col_d;
  logic [tgpe_pkg::ROW_W-1:0] row_q, row_d;

  // Output register.
  logic                         out_valid_q, out_valid_d;
  logic                         out_pix_q, out_pix_d, out_last_q, out_last_d;
  logic [CW-1:0]                out_x_q, out_x_d, out_y_q, out_y_d;
  logic [CW-1:0]                out_cx_q, out_cx_d, out_cy_q, out_cy_d;
  logic [tgpe_pkg::COLOR_W-1:0] out_color_q, out_color_d;
  logic                         out_free;

  // Font store.
  tgpe_pkg::font_wr_t           font_wr;
  tgpe_pkg::font_rd_t           font_rd;
  logic [tgpe_pkg::FONT_DW-1:0] font_rdata;
  logic                         font_ready;

  tgpe_font_mem u_font_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (font_wr),
    .rd_i    (font_rd),
    .rdata_o (font_rdata),
    .ready_o (font_ready)
  );

  // The one adder, shared by the cursor advance and both pixel coordinates.
  logic [CW-1:0] add_a, add_b;
  logic [CW:0]   add_sum;

  always_comb begin
    case (state_q)
      ST_ADV: begin
        add_a = cursor_col_q;
        add_b = GlyphColsW;
      end
      ST_ADV_Y: begin
        add_a = y0_q;
        add_b = GlyphRowsW;
      end
      ST_ROW: begin
        add_a = y0_q;
        add_b = CW'(row_q);
      end
      default: begin
        add_a = x0_q;
        add_b = CW'(col_q);
      end
    endcase
    add_sum = {1'b0, add_a} + {1'b0, add_b};
  end

  logic in_fire;
  logic col_end, row_end;

  assign s_axis_tready = (state_q == ST_IDLE) & font_ready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign col_end       = (col_q == tgpe_pkg::COL_W'(tgpe_pkg::GLYPH_COLS - 1));
  assign row_end       = (row_q == tgpe_pkg::ROW_W'(tgpe_pkg::GLYPH_ROWS - 1));

  always_comb begin
    state_d      = state_q;
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    x0_d         = x0_q;
    y0_d         = y0_q;
    pix_y_d      = pix_y_q;
    code_d       = code_q;
    col_d        = col_q;
    row_d        = row_q;

    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_pix_d    = out_pix_q;
    out_last_d   = out_last_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_cx_d     = out_cx_q;
    out_cy_d     = out_cy_q;
    out_color_d  = out_color_q;

    font_wr      = '0;
    font_rd      = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            tgpe_pkg::OP_PUT_CHAR: begin
              code_d  = in_char;
              x0_d    = cursor_col_q;
              y0_d    = cursor_row_q;
              col_d   = '0;
              row_d   = '0;
              state_d = ST_ADV;
            end
            tgpe_pkg::OP_SET_CURSOR: begin
              cursor_col_d = in_cur_x;
              cursor_row_d = in_cur_y;
              state_d      = ST_STAT;
            end
            tgpe_pkg::OP_FONT_WRITE: begin
              font_wr.en   = 1'b1;
              font_wr.addr = in_font_idx;
              font_wr.data = in_font_bits;
              state_d      = ST_STAT;
            end
            default: state_d = ST_STAT;
          endcase
        end
      end
      ST_ADV: begin
        // The sum is compared at 17 bits, so a column near the top still wraps.
        if (add_sum >= {1'b0, screen_width_q}) begin
          cursor_col_d = '0;
          state_d      = ST_ADV_Y;
        end else begin
          cursor_col_d = add_sum[CW-1:0];
          state_d      = ST_ROW;
        end
      end
      ST_ADV_Y: begin
        cursor_row_d = add_sum[CW-1:0];
        state_d      = ST_ROW;
      end
      ST_ROW: begin
        font_rd.en   = 1'b1;
        font_rd.addr = tgpe_pkg::FONT_AW'(32'(code_q) * tgpe_pkg::GLYPH_ROWS + 32'(row_q));
        pix_y_d      = add_sum[CW-1:0];
        col_d        = '0;
        state_d      = ST_PIX;
      end
      ST_PIX: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pix_d   = 1'b1;
          out_last_d  = col_end & row_end;
          out_x_d     = add_sum[CW-1:0];
          out_y_d     = pix_y_q;
          out_cx_d    = cursor_col_q;
          out_cy_d    = cursor_row_q;
          out_color_d = font_rdata[col_q] ? fg_color_q : bg_color_q;
          col_d       = col_q + 1'b1;
          if (col_end) begin
            if (row_end) begin
              state_d = ST_IDLE;
            end else begin
              row_d   = row_q + 1'b1;
              state_d = ST_ROW;
            end
          end
        end
      end
      ST_STAT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pix_d   = 1'b0;
          out_last_d  = 1'b1;
          out_x_d     = '0;
          out_y_d     = '0;
          out_cx_d    = cursor_col_q;
          out_cy_d    = cursor_row_q;
          out_color_d = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      col_q        <= '0;
      row_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      col_q        <= col_d;
      row_q        <= row_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q        <= x0_d;
    y0_q        <= y0_d;
    pix_y_q     <= pix_y_d;
    code_q      <= code_d;
    out_pix_q   <= out_pix_d;
    out_last_q  <= out_last_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_cx_q    <= out_cx_d;
    out_cy_q    <= out_cy_d;
    out_color_q <= out_color_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_cy_q, out_cx_q, out_color_q, out_y_q, out_x_q};
  assign m_axis_tuser  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of text_glyph_pixel_expander: stream and APB stimulus,
// a cycle-free predictor of pixel and status transactions, and an in-order checker.
// Depends on tgpe_pkg and the RTL of the block.
module tb_top;

  // Operation code that the block does not define; it must still give a status.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned IDLE_PCT = 31;
  localparam int unsigned RANDOM_PHASES = 4;
  localparam int unsigned ITEMS_PER_PHASE = 103;

  typedef struct packed {
    logic                         is_pixel;
    logic [tgpe_pkg::COORD_W-1:0] px;
    logic [tgpe_pkg::COORD_W-1:0] py;
    logic [tgpe_pkg::COLOR_W-1:0] color;
    logic [tgpe_pkg::COORD_W-1:0] cx;
    logic [tgpe_pkg::COORD_W-1:0] cy;
    logic                         last;
  } raster_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // char_code[7:0], new_cursor_x[23:8], new_cursor_y[39:24], font_index[50:40],
  // font_row_bits[58:51], zero fill [63:59]
  logic [63:0] s_axis_tdata;
  // operation[1:0]
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // pixel_x[15:0], pixel_y[31:16], pixel_color[63:32], cursor_x_now[79:64],
  // cursor_y_now[95:80]
  logic [95:0] m_axis_tdata;
  // is_pixel[0]
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: registers, cursor and a copy of the font store.
  logic [tgpe_pkg::COLOR_W-1:0] fg_now;
  logic [tgpe_pkg::COLOR_W-1:0] bg_now;
  logic [tgpe_pkg::COORD_W-1:0] width_now;
  logic [tgpe_pkg::COORD_W-1:0] col_now;
  logic [tgpe_pkg::COORD_W-1:0] row_now;
  logic [tgpe_pkg::FONT_DW-1:0] font_copy [tgpe_pkg::FONT_DEPTH];

  raster_beat_t raster_q [$];
  raster_beat_t seen_beat;
  raster_beat_t want_beat;
  int unsigned  mismatches;
  int unsigned  items_sent;
  bit           steady_flow;

  text_glyph_pixel_expander dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  initial begin
    #2_000_000;
    $display("FAIL text_glyph_pixel_expander");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 50) begin
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  function automatic raster_beat_t status_beat();
    raster_beat_t b;
    b          = '0;
    b.cx       = col_now;
    b.cy       = row_now;
    b.last     = 1'b1;
    return b;
  endfunction

  // Works out every output transaction that one accepted input causes.
  task automatic rasterise_item(input logic [1:0] op, input logic [63:0] d);
    raster_beat_t                 b;
    logic [7:0]                   code;
    logic [tgpe_pkg::COORD_W-1:0] x0;
    logic [tgpe_pkg::COORD_W-1:0] y0;
    logic [tgpe_pkg::COORD_W:0]   sum;
    logic [tgpe_pkg::FONT_AW-1:0] addr;
    logic [tgpe_pkg::FONT_DW-1:0] bits;
    int                           r;
    int                           c;
    case (op)
      tgpe_pkg::OP_PUT_CHAR: begin
        code = d[7:0];
        x0   = col_now;
        y0   = row_now;
        sum  = {1'b0, x0} + (tgpe_pkg::COORD_W + 1)'(tgpe_pkg::GLYPH_COLS);
        if (sum >= {1'b0, width_now}) begin
          col_now = '0;
          row_now = y0 + tgpe_pkg::COORD_W'(tgpe_pkg::GLYPH_ROWS);
        end else begin
          col_now = sum[tgpe_pkg::COORD_W-1:0];
        end
        for (r = 0; r < tgpe_pkg::GLYPH_ROWS; r++) begin
          addr = tgpe_pkg::FONT_AW'(int'(code) * tgpe_pkg::GLYPH_ROWS + r);
          bits = font_copy[addr];
          for (c = 0; c < tgpe_pkg::GLYPH_COLS; c++) begin
            b.is_pixel = 1'b1;
            b.px       = x0 + tgpe_pkg::COORD_W'(c);
            b.py       = y0 + tgpe_pkg::COORD_W'(r);
            b.color    = bits[c] ? fg_now : bg_now;
            b.cx       = col_now;
            b.cy       = row_now;
            b.last     = (r == tgpe_pkg::GLYPH_ROWS - 1) && (c == tgpe_pkg::GLYPH_COLS - 1);
            raster_q.push_back(b);
          end
        end
      end
      tgpe_pkg::OP_SET_CURSOR: begin
        col_now = d[23:8];
        row_now = d[39:24];
        raster_q.push_back(status_beat());
      end
      tgpe_pkg::OP_FONT_WRITE: begin
        font_copy[d[50:40]] = d[58:51];
        raster_q.push_back(status_beat());
      end
      default: begin
        raster_q.push_back(status_beat());
      end
    endcase
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_beat = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                   m_axis_tdata[63:32], m_axis_tdata[79:64], m_axis_tdata[95:80],
                   m_axis_tlast};
      if (raster_q.size() == 0) begin
        report_mismatch("unexpected output transaction", m_axis_tdata[31:0], '0);
      end else begin
        want_beat = raster_q.pop_front();
        if (seen_beat.is_pixel !== want_beat.is_pixel)
          report_mismatch("is_pixel", 32'(seen_beat.is_pixel), 32'(want_beat.is_pixel));
        if (seen_beat.px !== want_beat.px)
          report_mismatch("pixel_x", 32'(seen_beat.px), 32'(want_beat.px));
        if (seen_beat.py !== want_beat.py)
          report_mismatch("pixel_y", 32'(seen_beat.py), 32'(want_beat.py));
        if (seen_beat.color !== want_beat.color)
          report_mismatch("pixel_color", seen_beat.color, want_beat.color);
        if (seen_beat.cx !== want_beat.cx)
          report_mismatch("cursor_x_now", 32'(seen_beat.cx), 32'(want_beat.cx));
        if (seen_beat.cy !== want_beat.cy)
          report_mismatch("cursor_y_now", 32'(seen_beat.cy), 32'(want_beat.cy));
        if (seen_beat.last !== want_beat.last)
          report_mismatch("last", 32'(seen_beat.last), 32'(want_beat.last));
      end
    end
  end

  // One APB transfer; a read is checked against the predictor's register copy.
  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [31:0] wdata);
    logic [31:0] held;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (wr) begin
      case (idx)
        tgpe_pkg::REG_FG_COLOR:     fg_now    = wdata;
        tgpe_pkg::REG_BG_COLOR:     bg_now    = wdata;
        tgpe_pkg::REG_SCREEN_WIDTH: width_now = wdata[tgpe_pkg::COORD_W-1:0];
        default: ;
      endcase
    end else begin
      case (idx)
        tgpe_pkg::REG_FG_COLOR:     held = fg_now;
        tgpe_pkg::REG_BG_COLOR:     held = bg_now;
        default:                    held = 32'(width_now);
      endcase
      if (prdata !== held) report_mismatch("prdata", prdata, held);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_back_regs();
    apb_access(1'b0, tgpe_pkg::REG_FG_COLOR, '0);
    apb_access(1'b0, tgpe_pkg::REG_BG_COLOR, '0);
    apb_access(1'b0, tgpe_pkg::REG_SCREEN_WIDTH, '0);
  endtask

  task automatic program_regs(input logic [31:0] fg, input logic [31:0] bg,
                              input logic [15:0] width);
    apb_access(1'b1, tgpe_pkg::REG_FG_COLOR, fg);
    apb_access(1'b1, tgpe_pkg::REG_BG_COLOR, bg);
    apb_access(1'b1, tgpe_pkg::REG_SCREEN_WIDTH, 32'(width));
    read_back_regs();
  endtask

  // Leaves tvalid high after the transaction so that a following item keeps it up.
  task automatic send_item(input logic [1:0] op, input logic [63:0] d);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    rasterise_item(op, d);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Random content for the fields an operation does not use.
  function automatic logic [63:0] rand_fields();
    logic [63:0] d;
    d        = {$urandom, $urandom};
    d[63:59] = '0;
    return d;
  endfunction

  task automatic put_char(input logic [7:0] code);
    logic [63:0] d;
    d       = rand_fields();
    d[7:0]  = code;
    send_item(tgpe_pkg::OP_PUT_CHAR, d);
  endtask

  task automatic set_cursor(input logic [15:0] x, input logic [15:0] y);
    logic [63:0] d;
    d        = rand_fields();
    d[23:8]  = x;
    d[39:24] = y;
    send_item(tgpe_pkg::OP_SET_CURSOR, d);
  endtask

  task automatic write_font(input logic [tgpe_pkg::FONT_AW-1:0] idx,
                            input logic [7:0] bits);
    logic [63:0] d;
    d        = rand_fields();
    d[50:40] = idx;
    d[58:51] = bits;
    send_item(tgpe_pkg::OP_FONT_WRITE, d);
  endtask

  // Waits until every predicted transaction has arrived and the block has settled.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (raster_q.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic test_blank_font();
    read_back_regs();
    put_char(8'h00);
    put_char(8'hFF);
    wait_idle();
  endtask

  task automatic test_glyph_extremes();
    logic [7:0] rows [8];
    int         r;
    rows = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h0F, 8'hF0};
    for (r = 0; r < tgpe_pkg::GLYPH_ROWS; r++) begin
      write_font(tgpe_pkg::FONT_AW'(int'(8'h41) * tgpe_pkg::GLYPH_ROWS + r), rows[r % 8]);
    end
    write_font('0, 8'hFF);
    write_font('1, 8'h81);
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    // Both coordinates wrap inside the glyph, and the advance overflows 16 bits.
    set_cursor(16'hFFFC, 16'hFFFC);
    put_char(8'h41);
    set_cursor(16'hFFFF, 16'hFFFF);
    put_char(8'h41);
    send_item(OP_UNUSED, rand_fields());
    wait_idle();
  endtask

  task automatic test_register_extremes();
    logic [31:0] fgs    [4];
    logic [31:0] bgs    [4];
    logic [15:0] widths [4];
    logic [15:0] starts [4];
    int          s;
    fgs    = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF};
    bgs    = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8765_4321, 32'h0000_00FF};
    widths = '{16'd0, 16'd1, 16'd8, 16'hFFFF};
    starts = '{16'd0, 16'd0, 16'd0, 16'hFFF0};
    for (s = 0; s < 4; s++) begin
      program_regs(fgs[s], bgs[s], widths[s]);
      set_cursor(starts[s], 16'($urandom));
      put_char(8'h41);
      put_char(8'h41);
      wait_idle();
    end
  endtask

  // Defines a glyph, sometimes places the cursor and prints the glyph one to four times.
  task automatic glyph_sequence();
    logic [7:0] code;
    int         r;
    if ($urandom_range(0, 2) == 0) begin
      code = 8'($urandom);
    end else begin
      code = {($urandom_range(0, 1) ? 6'h3F : 6'h00), 2'($urandom)};
    end
    for (r = 0; r < tgpe_pkg::GLYPH_ROWS; r++) begin
      if ($urandom_range(0, 3) != 0) begin
        write_font(tgpe_pkg::FONT_AW'(int'(code) * tgpe_pkg::GLYPH_ROWS + r), 8'($urandom));
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      if ($urandom_range(0, 3) == 0) begin
        set_cursor(16'($urandom), 16'($urandom));
      end else begin
        set_cursor(16'($urandom_range(0, int'(width_now))), 16'($urandom_range(0, 511)));
      end
    end
    repeat ($urandom_range(1, 4)) put_char(code);
  endtask

  task automatic test_random_text();
    logic [15:0] width;
    int unsigned goal;
    int unsigned ph;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0:       width = 16'($urandom_range(1, 96));
        1:       width = 16'($urandom);
        2:       width = 16'(8 * $urandom_range(1, 12));
        default: width = 16'($urandom_range(0, 16));
      endcase
      program_regs($urandom, $urandom, width);
      // One phase runs with no idle gaps on the input and m_axis_tready always high.
      steady_flow = (ph == 2);
      goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < goal) begin
        if ($urandom_range(0, 99) < 65) begin
          glyph_sequence();
        end else begin
          send_item(2'($urandom), rand_fields());
        end
      end
      wait_idle();
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mismatches    = 0;
    items_sent    = 0;
    steady_flow   = 1'b0;
    fg_now        = tgpe_pkg::FG_COLOR_RST;
    bg_now        = tgpe_pkg::BG_COLOR_RST;
    width_now     = tgpe_pkg::SCREEN_WIDTH_RST;
    col_now       = '0;
    row_now       = '0;
    for (int i = 0; i < tgpe_pkg::FONT_DEPTH; i++) font_copy[i] = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_blank_font();
    test_glyph_extremes();
    test_register_extremes();
    test_random_text();

    wait_idle();
    repeat (100) @(negedge clk_i);
    if (raster_q.size() != 0) begin
      report_mismatch("transactions never received", 32'(raster_q.size()), 0);
    end
    if (mismatches == 0) begin
      $display("PASS text_glyph_pixel_expander");
    end else begin
      $display("FAIL text_glyph_pixel_expander");
    end
    $finish;
  end

endmodule
